@@ hw/rtl/mrtd_pkg.sv @@
// Package for the multi-rate tick divider: widths, codes and states.
`timescale 1ns / 1ps

package mrtd_pkg;

    // Fixed field widths
    localparam int OPC_W    = 2;
    localparam int RATE_W   = 14;
    localparam int TGT_W    = 4;
    localparam int STAT_W   = 2;
    localparam int SLOTN_W  = 4;
    localparam int PERIOD_W = 20;
    localparam int OP_W     = PERIOD_W + 1;   // shared add/sub unit, signed headroom
    localparam int DCNT_W   = $clog2(PERIOD_W);

    localparam int SLOTS_DEF = 16;

    // Divider and rate checks
    localparam logic [PERIOD_W-1:0] BASE_RATE  = PERIOD_W'(1000000);
    localparam logic [RATE_W-1:0]   RATE_LIMIT = RATE_W'(10000);

    // Firings reported per tick
    localparam int FIRE_CNT_W = 5;
    localparam logic [FIRE_CNT_W-1:0] MAX_FIRES = FIRE_CNT_W'(16);

    typedef enum logic [OPC_W-1:0] {
        OP_TICK   = 2'd0,
        OP_ATTACH = 2'd1,
        OP_DETACH = 2'd2,
        OP_RSVD   = 2'd3
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_RATE = 2'd1,
        ST_FULL     = 2'd2,
        ST_BAD_SLOT = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_ATTACH,
        S_RD,
        S_SUB,
        S_ADD,
        S_END
    } t_state;

endpackage

@@ hw/rtl/multi_rate_tick_divider.sv @@
// Top level of the multi-rate tick divider: slot table, sequencer and shared adder.
`timescale 1ns / 1ps

// Multi-rate tick divider. A table of up to SLOTS channels derived from one
// shared tick. A transaction is taken on a rising edge where start is high
// and busy is low. Each result is shown for one cycle, marked by o_valid, and
// cannot be held off, so the receiver must take every strobed result. Every
// sequence of results ends with one marked o_last.
//   attach  : restoring divide of BASE_RATE by the rate, one quotient bit per
//             cycle on the shared add/sub unit in S_DIV, then S_ATTACH writes
//             the slot and registers the result.
//             A bad rate or a full table answers in the next cycle, not busy.
//   detach  : answered in the next cycle, no busy time.
//   tick    : three steps per occupied slot (memory read in S_RD, subtract
//             interval in S_SUB, add period back and write in S_ADD), then
//             S_END for the end result.
//             With an empty table only the end result comes, in the next
//             cycle, with no busy time.
//             Fired slots stream out during the walk, at most one per slot
//             visit and at most 16 per tick.
//   opcode 3: taken and ignored, no result.
// Countdown and period live in single write port tables with registered
// reads; the memory port and the shared adder set the per-slot cost.
// A new transaction may be taken in the cycle the final result is shown.
module multi_rate_tick_divider #(
    parameter int SLOTS = mrtd_pkg::SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [mrtd_pkg::OPC_W-1:0]   i_opcode,
    input  logic [mrtd_pkg::RATE_W-1:0]  i_rate_hz,
    input  logic [mrtd_pkg::TGT_W-1:0]   i_target_slot,
    output logic                         o_valid,
    output logic [mrtd_pkg::STAT_W-1:0]  o_status,
    output logic [mrtd_pkg::SLOTN_W-1:0] o_slot_number,
    output logic                         o_fired,
    output logic                         o_last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (CNT_W > mrtd_pkg::TGT_W) ? CNT_W : mrtd_pkg::TGT_W;
    localparam int PW    = mrtd_pkg::PERIOD_W;
    localparam int RW    = mrtd_pkg::RATE_W;
    localparam int OW    = mrtd_pkg::OP_W;

    // Sequencer state
    mrtd_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0]                  r_idx, n_idx;
    logic [CNT_W-1:0]                  r_used, n_used;
    logic [PW-1:0]                     r_interval, n_interval;
    logic [RW-1:0]                     r_highest, n_highest;
    logic [SLOTS-1:0]                  r_en, n_en;
    logic [mrtd_pkg::FIRE_CNT_W-1:0]   r_nfire, n_nfire;

    // Divider
    logic [RW-1:0]                     r_rate, n_rate;
    logic [RW-1:0]                     r_rem, n_rem;
    logic [PW-1:0]                     r_q, n_q;
    logic [mrtd_pkg::DCNT_W-1:0]       r_cnt, n_cnt;

    // Tick walk
    logic [OW-1:0]                     r_diff, n_diff;
    logic                              r_fire, n_fire;

    // Result register
    logic                              r_valid, n_valid;
    mrtd_pkg::t_status                 r_status, n_status;
    logic [mrtd_pkg::SLOTN_W-1:0]      r_slot, n_slot;
    logic                              r_fired, n_fired;
    logic                              r_last, n_last;

    // Slot tables
    logic [PW-1:0] mem_cd  [SLOTS];
    logic [PW-1:0] mem_per [SLOTS];
    logic [PW-1:0] r_cd_rd, r_per_rd;
    logic          cd_we, per_we;
    logic [IDX_W-1:0] wr_addr;
    logic [PW-1:0] wr_cd;

    // Shared add/sub unit
    logic [OW-1:0] u_a, u_b, u_res;
    logic          u_sub;

    assign u_res = u_a + (u_sub ? ~u_b : u_b) + OW'(u_sub);

    logic [RW:0] rem_sh;
    assign rem_sh = {r_rem, r_q[PW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mrtd_pkg::S_IDLE;
            r_used     <= '0;
            r_interval <= '0;
            r_highest  <= '0;
            r_en       <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_interval <= n_interval;
            r_highest  <= n_highest;
            r_en       <= n_en;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_nfire  <= n_nfire;
        r_rate   <= n_rate;
        r_rem    <= n_rem;
        r_q      <= n_q;
        r_cnt    <= n_cnt;
        r_diff   <= n_diff;
        r_fire   <= n_fire;
        r_status <= n_status;
        r_slot   <= n_slot;
        r_fired  <= n_fired;
        r_last   <= n_last;
    end

    // Tables: one write port, registered read at the walk index
    always_ff @(posedge i_clk) begin
        r_cd_rd  <= mem_cd[r_idx];
        r_per_rd <= mem_per[r_idx];
        if (cd_we) begin
            mem_cd[wr_addr] <= wr_cd;
        end
        if (per_we) begin
            mem_per[wr_addr] <= r_q;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_used     = r_used;
        n_interval = r_interval;
        n_highest  = r_highest;
        n_en       = r_en;
        n_nfire    = r_nfire;
        n_rate     = r_rate;
        n_rem      = r_rem;
        n_q        = r_q;
        n_cnt      = r_cnt;
        n_diff     = r_diff;
        n_fire     = r_fire;
        n_valid    = 1'b0;
        n_status   = r_status;
        n_slot     = r_slot;
        n_fired    = r_fired;
        n_last     = r_last;
        cd_we      = 1'b0;
        per_we     = 1'b0;
        wr_addr    = r_idx;
        wr_cd      = r_diff[PW-1:0];
        u_a        = OW'(rem_sh);
        u_b        = OW'(r_rate);
        u_sub      = 1'b1;

        unique case (r_state)
            mrtd_pkg::S_IDLE: begin
                if (start) begin
                    unique case (mrtd_pkg::t_opcode'(i_opcode))
                        mrtd_pkg::OP_ATTACH: begin
                            if (i_rate_hz == '0 || i_rate_hz > mrtd_pkg::RATE_LIMIT) begin
                                n_valid  = 1'b1;
                                n_status = mrtd_pkg::ST_BAD_RATE;
                                n_slot   = '0;
                                n_fired  = 1'b0;
                                n_last   = 1'b1;
                            end else if (r_used >= CNT_W'(SLOTS)) begin
                                n_valid  = 1'b1;
                                n_status = mrtd_pkg::ST_FULL;
                                n_slot   = '0;
                                n_fired  = 1'b0;
                                n_last   = 1'b1;
                            end else begin
                                n_rate  = i_rate_hz;
                                n_rem   = '0;
                                n_q     = mrtd_pkg::BASE_RATE;
                                n_cnt   = '0;
                                n_state = mrtd_pkg::S_DIV;
                            end
                        end
                        mrtd_pkg::OP_DETACH: begin
                            n_valid = 1'b1;
                            n_slot  = i_target_slot;
                            n_fired = 1'b0;
                            n_last  = 1'b1;
                            if (CMP_W'(i_target_slot) >= CMP_W'(r_used)) begin
                                n_status = mrtd_pkg::ST_BAD_SLOT;
                            end else begin
                                n_status = mrtd_pkg::ST_OK;
                                n_en[IDX_W'(i_target_slot)] = 1'b0;
                            end
                        end
                        mrtd_pkg::OP_TICK: begin
                            n_nfire = '0;
                            n_idx   = '0;
                            if (r_used == '0) begin
                                n_valid  = 1'b1;
                                n_status = mrtd_pkg::ST_OK;
                                n_slot   = '0;
                                n_fired  = 1'b0;
                                n_last   = 1'b1;
                            end else begin
                                n_state = mrtd_pkg::S_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // One quotient bit per cycle
            mrtd_pkg::S_DIV: begin
                if (!u_res[OW-1]) begin
                    n_rem = u_res[RW-1:0];
                    n_q   = {r_q[PW-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[RW-1:0];
                    n_q   = {r_q[PW-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == mrtd_pkg::DCNT_W'(PW - 1)) begin
                    n_state = mrtd_pkg::S_ATTACH;
                end
            end

            mrtd_pkg::S_ATTACH: begin
                wr_addr = IDX_W'(r_used);
                wr_cd   = r_q;
                cd_we   = 1'b1;
                per_we  = 1'b1;
                n_en[IDX_W'(r_used)] = 1'b1;
                n_used  = r_used + 1'b1;
                if (r_rate > r_highest) begin
                    n_interval = r_q;
                    n_highest  = r_rate;
                end
                n_valid  = 1'b1;
                n_status = mrtd_pkg::ST_OK;
                n_slot   = mrtd_pkg::SLOTN_W'(r_used);
                n_fired  = 1'b0;
                n_last   = 1'b1;
                n_state  = mrtd_pkg::S_IDLE;
            end

            mrtd_pkg::S_RD: begin
                n_state = mrtd_pkg::S_SUB;
            end

            // countdown - interval; fires at zero or below
            mrtd_pkg::S_SUB: begin
                u_a     = OW'(r_cd_rd);
                u_b     = OW'(r_interval);
                u_sub   = 1'b1;
                n_diff  = u_res;
                n_fire  = u_res[OW-1] || (u_res == '0);
                n_state = mrtd_pkg::S_ADD;
            end

            // add the period back on a firing, write back, report
            mrtd_pkg::S_ADD: begin
                u_a   = r_diff;
                u_b   = OW'(r_per_rd);
                u_sub = 1'b0;
                cd_we = 1'b1;
                wr_cd = r_fire ? u_res[PW-1:0] : r_diff[PW-1:0];
                if (r_fire && r_en[r_idx] && r_nfire < mrtd_pkg::MAX_FIRES) begin
                    n_valid  = 1'b1;
                    n_status = mrtd_pkg::ST_OK;
                    n_slot   = mrtd_pkg::SLOTN_W'(r_idx);
                    n_fired  = 1'b1;
                    n_last   = 1'b0;
                    n_nfire  = r_nfire + 1'b1;
                end
                if (CNT_W'(r_idx) + 1'b1 == r_used) begin
                    n_state = mrtd_pkg::S_END;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = mrtd_pkg::S_RD;
                end
            end

            mrtd_pkg::S_END: begin
                n_valid  = 1'b1;
                n_status = mrtd_pkg::ST_OK;
                n_slot   = '0;
                n_fired  = 1'b0;
                n_last   = 1'b1;
                n_state  = mrtd_pkg::S_IDLE;
            end

            default: begin
                n_state = mrtd_pkg::S_IDLE;
            end
        endcase
    end

    assign busy          = (r_state != mrtd_pkg::S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_slot_number = r_slot;
    assign o_fired       = r_fired;
    assign o_last        = r_last;

endmodule

@@ hw/rtl/mrtd_checker.sv @@
// Port-level checker for the multi-rate tick divider, bound to the top level.
`timescale 1ns / 1ps

module mrtd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [mrtd_pkg::OPC_W-1:0]   i_opcode,
    input logic [mrtd_pkg::RATE_W-1:0]  i_rate_hz,
    input logic [mrtd_pkg::TGT_W-1:0]   i_target_slot,
    input logic                         o_valid,
    input logic [mrtd_pkg::STAT_W-1:0]  o_status,
    input logic [mrtd_pkg::SLOTN_W-1:0] o_slot_number,
    input logic                         o_fired,
    input logic                         o_last
);

    logic acc;
    assign acc = start && !busy;

    // Reserved opcode produces nothing
    a_rsvd_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_opcode == mrtd_pkg::OP_RSVD |=> !o_valid)
        else $error("result after reserved opcode");

    // Firing reports are ok and never the final result
    a_fire_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_fired |-> !o_last && o_status == mrtd_pkg::ST_OK)
        else $error("bad firing result");

    // More results pending means the block is still busy
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("idle with results outstanding");

    // Detach answers at once with its own slot number
    a_detach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_opcode == mrtd_pkg::OP_DETACH
        |=> o_valid && o_last && o_slot_number == $past(i_target_slot))
        else $error("detach result wrong");

    // A zero rate is rejected at once
    a_zero_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_opcode == mrtd_pkg::OP_ATTACH && i_rate_hz == '0
        |=> o_valid && o_last && o_status == mrtd_pkg::ST_BAD_RATE)
        else $error("zero rate not rejected");

endmodule

bind multi_rate_tick_divider mrtd_checker u_mrtd_checker (.*);
